FILE: hw/rtl/bfer_pkg.sv
// shared types and constants for the backlight fade easing ramp
`timescale 1ns / 1ps

package bfer_pkg;

    // default widths of the fade length and of the easing fraction
    localparam int DEF_DURATION_BITS = 24;
    localparam int DEF_FRACTION_BITS = 16;

    // inverted panels emit this base minus the level, modulo 256
    localparam logic [7:0] INVERT_BASE = 8'h80;

    // input action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_POW,
        S_ADD,
        S_OUT
    } bfer_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start_latch;
        logic tick_dec;
        logic tick_stop;
        logic tick_fire;
        logic level_end;
        logic div_init;
        logic div_step;
        logic pow_step;
        logic mag_mul;
        logic level_add;
        logic emit;
    } bfer_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic action;
        logic busy;
        logic wait_gt1;
        logic past_end;
        logic end_case;
        logic div_last;
        logic pow_done;
        logic out_free;
    } bfer_sts_t;

endpackage

FILE: hw/rtl/bfer_if.sv
// item channels and configuration write channel of the fade ramp
`timescale 1ns / 1ps

// input item channel
interface bfer_req_if #(
    parameter int DURATION_BITS = bfer_pkg::DEF_DURATION_BITS
);
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [7:0]               start_level;
    logic [7:0]               end_level;
    logic [DURATION_BITS-1:0] duration_ms;
    logic [1:0]               curve;
    logic [7:0]               step_interval;

    modport source (
        output valid, action, start_level, end_level, duration_ms, curve, step_interval,
        input  ready
    );
    modport sink (
        input  valid, action, start_level, end_level, duration_ms, curve, step_interval,
        output ready
    );
endinterface

// result item channel
interface bfer_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       last;

    modport source (
        output valid, duty, last,
        input  ready
    );
    modport sink (
        input  valid, duty, last,
        output ready
    );
endinterface

// configuration write channel
interface bfer_cfg_if;
    logic valid;
    logic ready;
    logic invert_duty;

    modport source (
        output valid, invert_duty,
        input  ready
    );
    modport sink (
        input  valid, invert_duty,
        output ready
    );
endinterface

FILE: hw/rtl/bfer_ctrl.sv
// sequencing state machine of the fade ramp
`timescale 1ns / 1ps

module bfer_ctrl
    import bfer_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  bfer_sts_t sts,
    output bfer_cmd_t cmd
);

    bfer_state_t state_reg;
    bfer_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.action == ACT_START)
                    begin
                        if (!sts.busy)
                        begin
                            cmd.start_latch = 1'b1;
                            state_next      = S_EVAL;
                        end
                    end
                    else if (sts.busy)
                    begin
                        priority if (sts.wait_gt1)
                        begin
                            cmd.tick_dec = 1'b1;
                        end
                        else if (sts.past_end)
                        begin
                            cmd.tick_stop = 1'b1;
                        end
                        else
                        begin
                            cmd.tick_fire = 1'b1;
                            state_next    = S_EVAL;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                if (sts.end_case)
                begin
                    cmd.level_end = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (sts.pow_done)
                begin
                    cmd.mag_mul = 1'b1;
                    state_next  = S_ADD;
                end
                else
                begin
                    cmd.pow_step = 1'b1;
                end
            end
            S_ADD:
            begin
                cmd.level_add = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bfer_datapath.sv
// fade state, divider, power and level arithmetic, output register
`timescale 1ns / 1ps

module bfer_datapath
    import bfer_pkg::*;
#(
    parameter int DURATION_BITS = DEF_DURATION_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bfer_cmd_t                cmd,
    output bfer_sts_t                sts,
    input  logic                     action,
    input  logic [7:0]               start_level,
    input  logic [7:0]               end_level,
    input  logic [DURATION_BITS-1:0] duration_ms,
    input  logic [1:0]               curve,
    input  logic [7:0]               step_interval,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               duty,
    output logic                     last,
    input  logic                     cfg_valid,
    input  logic                     cfg_invert
);

    localparam int DB = DURATION_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int CW = $clog2(FB);

    // fade state
    logic                 busy_reg;
    logic [DB:0]          elapsed_reg;
    logic [7:0]           wait_reg;
    logic [7:0]           base_reg;
    logic signed [8:0]    span_reg;
    logic [DB-1:0]        fade_reg;
    logic [7:0]           interval_reg;
    logic [1:0]           curve_reg;
    logic                 invert_reg;

    // arithmetic registers
    logic [DB-1:0]        rem_reg;
    logic [FB-1:0]        t_reg;
    logic [CW-1:0]        div_cnt_reg;
    logic [FB-1:0]        p_reg;
    logic [1:0]           pow_cnt_reg;
    logic [FB+7:0]        mag_reg;
    logic [7:0]           level_reg;

    // output register
    logic                 out_valid_reg;
    logic [7:0]           duty_reg;
    logic                 last_reg;

    logic [DB:0]          fade_ext;
    logic [DB:0]          rem_dbl;
    logic [DB:0]          rem_sub;
    logic                 rem_ge;
    logic [DB-1:0]        rem_next;
    logic [FB-1:0]        q_next;
    logic [2*FB-1:0]      pow_prod;
    logic [8:0]           span_neg;
    logic [7:0]           span_mag;
    logic [FB+7:0]        mag_prod;
    logic [FB+8:0]        acc;
    logic [FB+8:0]        lvl_sum;
    logic [7:0]           end_lvl;
    logic [DB:0]          elapsed_sum;
    logic                 emit_last;
    logic [7:0]           duty_val;
    logic [7:0]           interval_in;
    logic                 out_free;

    // restoring divider step, one quotient bit a cycle
    assign fade_ext = {1'b0, fade_reg};
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_ge   = (rem_dbl >= fade_ext);
    assign rem_sub  = rem_dbl - fade_ext;
    assign rem_next = rem_ge ? rem_sub[DB-1:0] : rem_dbl[DB-1:0];
    assign q_next   = {t_reg[FB-2:0], rem_ge};

    // power step, truncated after each product
    assign pow_prod = {{FB{1'b0}}, p_reg} * {{FB{1'b0}}, t_reg};

    // span magnitude times power
    assign span_neg = 9'd0 - span_reg;
    assign span_mag = span_reg[8] ? span_neg[7:0] : span_reg[7:0];
    assign mag_prod = {{FB{1'b0}}, span_mag} * {8'd0, p_reg};

    // base level plus or minus the scaled span
    assign acc     = {1'b0, base_reg, {FB{1'b0}}};
    assign lvl_sum = span_reg[8] ? (acc - {1'b0, mag_reg}) : (acc + {1'b0, mag_reg});
    assign end_lvl = base_reg + span_reg[7:0];

    // time of the next update and final-update flag
    assign elapsed_sum = elapsed_reg + {{(DB-7){1'b0}}, interval_reg};
    assign emit_last   = (elapsed_sum > fade_ext);
    assign duty_val    = invert_reg ? (INVERT_BASE - level_reg) : level_reg;
    assign interval_in = (step_interval == 8'd0) ? 8'd1 : step_interval;
    assign out_free    = !out_valid_reg || out_ready;

    // status to the controller
    always_comb
    begin
        sts.action   = action;
        sts.busy     = busy_reg;
        sts.wait_gt1 = (wait_reg > 8'd1);
        sts.past_end = (elapsed_reg > fade_ext);
        sts.end_case = (fade_reg == '0) || (elapsed_reg >= fade_ext);
        sts.div_last = (div_cnt_reg == CW'(FB - 1));
        sts.pow_done = (pow_cnt_reg == curve_reg);
        sts.out_free = out_free;
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            invert_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_latch)
            begin
                busy_reg <= 1'b1;
            end
            else if (cmd.tick_stop)
            begin
                busy_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                invert_reg <= cfg_invert;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // fade parameters and timing
    always_ff @(posedge clk)
    begin
        if (cmd.start_latch)
        begin
            base_reg     <= start_level;
            span_reg     <= $signed({1'b0, end_level}) - $signed({1'b0, start_level});
            fade_reg     <= duration_ms;
            curve_reg    <= curve;
            interval_reg <= interval_in;
            elapsed_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            elapsed_reg <= elapsed_sum;
        end
        priority if (cmd.tick_dec)
        begin
            wait_reg <= wait_reg - 8'd1;
        end
        else if (cmd.tick_fire || cmd.tick_stop)
        begin
            wait_reg <= 8'd0;
        end
        else if (cmd.emit)
        begin
            wait_reg <= interval_reg;
        end
    end

    // divider, power and level registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg     <= elapsed_reg[DB-1:0];
            t_reg       <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            t_reg       <= q_next;
            div_cnt_reg <= div_cnt_reg + CW'(1);
        end
        if (cmd.div_step && sts.div_last)
        begin
            p_reg       <= q_next;
            pow_cnt_reg <= 2'd0;
        end
        else if (cmd.pow_step)
        begin
            p_reg       <= pow_prod[2*FB-1:FB];
            pow_cnt_reg <= pow_cnt_reg + 2'd1;
        end
        if (cmd.mag_mul)
        begin
            mag_reg <= mag_prod;
        end
        if (cmd.level_end)
        begin
            level_reg <= end_lvl;
        end
        else if (cmd.level_add)
        begin
            level_reg <= lvl_sum[FB+7:FB];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            duty_reg <= duty_val;
            last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    // a result is loaded only when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over a pending item");

    // arithmetic runs only inside a fade
    a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_init || cmd.div_step || cmd.pow_step || cmd.emit) |-> busy_reg)
        else $error("arithmetic outside a fade");

    // divider remainder stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < fade_reg))
        else $error("divider remainder out of range");

    // after the final update the next check stops the fade
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && emit_last) |=> (elapsed_reg > fade_ext))
        else $error("final update without end of fade");
`endif

endmodule

FILE: hw/rtl/backlight_fade_easing_ramp_core.sv
// top level of the backlight fade easing ramp
`timescale 1ns / 1ps

// Backlight PWM fade with linear, quadratic, cubic or quartic easing. A start
// item latches the levels, curve and step interval and yields the start level
// (the end level when the duration is zero); every step_interval ticks after
// that the block yields start + span * t^n (n = curve + 1) with t = elapsed /
// duration in Q0.FRACTION_BITS, until elapsed passes the duration. For an
// eased result the restoring divider produces one quotient bit a cycle, then
// the power multiplier iterates once per curve order, and the span multiply,
// the level add and the output load follow in turn. A result at the end
// level (zero duration, or the update that lands on the duration) skips the
// arithmetic. Either kind waits longer while the output register still holds
// an earlier result. A finished result sits in the output register, so the
// next item is accepted while it waits. invert_duty is written through the
// configuration channel, which is always ready.
module backlight_fade_easing_ramp_core
    import bfer_pkg::*;
#(
    parameter int DURATION_BITS = DEF_DURATION_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    bfer_req_if.sink       req,
    bfer_rsp_if.source     rsp,
    bfer_cfg_if.sink       cfg
);

    bfer_cmd_t cmd;
    bfer_sts_t sts;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    // controller
    bfer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    bfer_datapath #(
        .DURATION_BITS (DURATION_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (req.action),
        .start_level   (req.start_level),
        .end_level     (req.end_level),
        .duration_ms   (req.duration_ms),
        .curve         (req.curve),
        .step_interval (req.step_interval),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .duty          (rsp.duty),
        .last          (rsp.last),
        .cfg_valid     (cfg.valid),
        .cfg_invert    (cfg.invert_duty)
    );

endmodule

FILE: tb/tb_backlight_fade_easing_ramp_core.sv
// self-checking testbench for the backlight fade easing ramp core
`timescale 1ns / 1ps

module tb_backlight_fade_easing_ramp_core;
    import bfer_pkg::*;

    localparam int          DUR_W         = DEF_DURATION_BITS;
    localparam int          FRAC_W        = DEF_FRACTION_BITS;
    localparam int          CLK_PERIOD    = 8;
    localparam int          SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic             action;
        logic [7:0]       start_level;
        logic [7:0]       end_level;
        logic [DUR_W-1:0] duration_ms;
        logic [1:0]       curve;
        logic [7:0]       step_interval;
    } fade_req_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } duty_upd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfer_req_if #(.DURATION_BITS(DUR_W)) req_ch ();
    bfer_rsp_if rsp_ch ();
    bfer_cfg_if cfg_ch ();

    backlight_fade_easing_ramp_core #(
        .DURATION_BITS(DUR_W),
        .FRACTION_BITS(FRAC_W)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source),
        .cfg  (cfg_ch.sink)
    );

    // predicted fade state
    logic               fading    = 1'b0;
    logic [DUR_W:0]     fade_pos  = '0;
    logic [7:0]         tick_wait = '0;
    logic [7:0]         lvl_base  = '0;
    logic signed [8:0]  lvl_delta = '0;
    logic [DUR_W-1:0]   fade_len  = '0;
    logic [7:0]         step_len  = 8'd1;
    logic [1:0]         ease      = '0;
    logic               inv_duty  = 1'b0;

    duty_upd_t   duty_expect_q[$];
    bit          quiet  = 1'b0;
    bit          req_up = 1'b0;
    int unsigned items_sent, live_items, fades_started, starts_ignored;
    int unsigned updates_checked, errors;
    int unsigned cycle_count = 0;

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // gap length: mostly short, sometimes long
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    // eased level at the current fade position
    function automatic logic [7:0] ramp_level();
        logic [63:0] frac, pw, acc, mag;
        int          span;
        span = lvl_delta;
        if (fade_len == 0 || fade_pos >= fade_len)
            return 8'(int'(lvl_base) + span);
        frac = (64'(fade_pos) << FRAC_W) / 64'(fade_len);
        pw   = frac;
        for (int k = 0; k < int'(ease); k++)
            pw = (pw * frac) >> FRAC_W;
        acc = 64'(lvl_base) << FRAC_W;
        if (span >= 0)
            acc = acc + 64'(span) * pw;
        else
        begin
            mag = 64'(-span) * pw;
            acc = (mag > acc) ? 64'd0 : acc - mag;
        end
        return 8'(acc >> FRAC_W);
    endfunction

    // emit the next duty update, or close the fade once past its end
    function automatic void emit_update();
        duty_upd_t upd;
        if (fade_pos > {1'b0, fade_len})
        begin
            fading = 1'b0;
            return;
        end
        upd.duty = ramp_level();
        if (inv_duty)
            upd.duty = INVERT_BASE - upd.duty;
        fade_pos  = fade_pos + step_len;
        tick_wait = step_len;
        upd.last  = (fade_pos > {1'b0, fade_len});
        duty_expect_q = {duty_expect_q, upd};
    endfunction

    // update predicted state for one accepted item
    function automatic void predict_item(input fade_req_t item);
        if (item.action == ACT_START)
        begin
            if (fading)
            begin
                starts_ignored++;
                return;
            end
            fading    = 1'b1;
            lvl_base  = item.start_level;
            lvl_delta = 9'(int'(item.end_level) - int'(item.start_level));
            fade_len  = item.duration_ms;
            ease      = item.curve;
            step_len  = (item.step_interval == 0) ? 8'd1 : item.step_interval;
            fade_pos  = '0;
            fades_started++;
            live_items++;
            emit_update();
        end
        else if (fading)
        begin
            live_items++;
            if (tick_wait > 1)
                tick_wait--;
            else
            begin
                tick_wait = '0;
                emit_update();
            end
        end
    endfunction

    // item with every field random
    function automatic fade_req_t noise_item(input logic act);
        fade_req_t r;
        r.action        = act;
        r.start_level   = 8'($urandom);
        r.end_level     = 8'($urandom);
        r.duration_ms   = DUR_W'($urandom);
        r.curve         = 2'($urandom);
        r.step_interval = 8'($urandom);
        return r;
    endfunction

    function automatic fade_req_t fade_start(input logic [7:0] s, input logic [7:0] e,
                                             input logic [DUR_W-1:0] dur,
                                             input logic [1:0] crv, input logic [7:0] iv);
        return '{ACT_START, s, e, dur, crv, iv};
    endfunction

    function automatic logic [7:0] random_level();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        return (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    endfunction

    // fade start biased toward fades that finish in a few dozen ticks
    function automatic fade_req_t random_fade();
        fade_req_t   r;
        int unsigned pick;
        r = fade_start(random_level(), random_level(), '0, 2'($urandom), 8'd1);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.step_interval = 8'd0;
        else if (pick < 85)
            r.step_interval = 8'($urandom_range(1, 6));
        else if (pick < 97)
            r.step_interval = 8'($urandom_range(7, 40));
        else
            r.step_interval = 8'($urandom_range(41, 255));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.duration_ms = '0;
        else if (pick < 90)
            r.duration_ms = DUR_W'($urandom_range(1, 30));
        else if (pick < 97)
            r.duration_ms = DUR_W'($urandom_range(31, 120));
        else
        begin
            r.duration_ms   = DUR_W'($urandom_range(200, 600));
            r.step_interval = 8'($urandom_range(16, 255));
        end
        return r;
    endfunction

    // send one item and wait for its handshake
    task automatic send_item(input fade_req_t item);
        int unsigned gap;
        req_ch.valid         <= 1'b1;
        req_ch.action        <= item.action;
        req_ch.start_level   <= item.start_level;
        req_ch.end_level     <= item.end_level;
        req_ch.duration_ms   <= item.duration_ms;
        req_ch.curve         <= item.curve;
        req_ch.step_interval <= item.step_interval;
        req_up = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        predict_item(item);
        gap = (quiet || $urandom_range(0, 1)) ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every predicted update has arrived
    task automatic wait_results_done();
        if (req_up)
        begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
            @(posedge clk);
        end
        while (duty_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic tick_until_idle();
        while (fading)
            send_item(noise_item(ACT_TICK));
    endtask

    // register write, only with the block idle
    task automatic write_invert(input logic v);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.invert_duty <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        inv_duty = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // well-formed fades with idle ticks and ignored starts mixed in
    task automatic run_random_fades(input int unsigned target);
        int unsigned stop_at;
        stop_at = live_items + target;
        while (live_items < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(noise_item(ACT_TICK));
            send_item(random_fade());
            while (fading)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(noise_item(ACT_START));
                else
                    send_item(noise_item(ACT_TICK));
                if ($urandom_range(0, 199) == 0)
                    wait_results_done();
            end
        end
    endtask

    // extremes of levels and duration, every curve, zero interval and duration
    task automatic test_directed_cases();
        send_item(noise_item(ACT_TICK));
        send_item(fade_start(8'd0, 8'd255, '0, 2'd0, 8'd5));
        send_item(fade_start(8'd255, 8'd0, '1, 2'd3, 8'd0));
        tick_until_idle();
        send_item(fade_start(8'd255, 8'd0, DUR_W'(6), 2'd3, 8'd0));
        tick_until_idle();
        send_item(fade_start(8'd0, 8'd255, DUR_W'(3), 2'd2, 8'd2));
        tick_until_idle();
        send_item(fade_start(8'd1, 8'd254, DUR_W'(2), 2'd1, 8'd1));
        tick_until_idle();
    endtask

    // inverted panel output, then random fades with it
    task automatic test_inverted_panel();
        write_invert(1'b1);
        send_item(fade_start(8'd0, 8'd255, DUR_W'(4), 2'd0, 8'd1));
        tick_until_idle();
        run_random_fades(480);
    endtask

    // back-to-back stream, no random gaps on either side
    task automatic test_quiet_stream();
        write_invert(1'b0);
        quiet = 1'b1;
        run_random_fades(480);
        wait_results_done();
        quiet = 1'b0;
    endtask

    // random fades with gaps and sender holds
    task automatic test_mixed_stream();
        write_invert(1'b1);
        run_random_fades(450);
    endtask

    // one fade over a huge duration, left running at the end
    task automatic test_long_fade();
        fade_req_t r;
        write_invert(1'($urandom));
        r = random_fade();
        r.duration_ms   = {1'b1, (DUR_W - 1)'($urandom)};
        r.step_interval = 8'($urandom_range(1, 4));
        send_item(r);
        repeat (60)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(noise_item(ACT_START));
            else
                send_item(noise_item(ACT_TICK));
        end
    endtask

    // compare each duty update with the oldest prediction
    always @(posedge clk)
    begin : duty_check
        duty_upd_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (duty_expect_q.size() == 0)
            begin
                $display("%0t: unexpected update, expected none, actual duty %0d last %0b",
                         $time, rsp_ch.duty, rsp_ch.last);
                errors++;
            end
            else
            begin
                want = duty_expect_q.pop_front();
                updates_checked++;
                if (rsp_ch.duty !== want.duty)
                begin
                    $display("%0t: duty wrong, expected %0d actual %0d",
                             $time, want.duty, rsp_ch.duty);
                    errors++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $display("%0t: last wrong, expected %0b actual %0b",
                             $time, want.last, rsp_ch.last);
                    errors++;
                end
            end
        end
    end

    // receiver pacing
    initial
    begin : sink_pacing
        int unsigned gap;
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = quiet ? 0 : pick_gap();
            if (gap != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // test sequence
    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.action        = ACT_TICK;
        req_ch.start_level   = '0;
        req_ch.end_level     = '0;
        req_ch.duration_ms   = '0;
        req_ch.curve         = '0;
        req_ch.step_interval = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.invert_duty   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_inverted_panel();
        test_quiet_stream();
        test_mixed_stream();
        test_long_fade();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d items: %0d fades started, %0d starts while busy",
                 items_sent, fades_started, starts_ignored);
        $display("checked %0d duty updates with invert_duty at both settings",
                 updates_checked);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bfer_pkg.sv
hw/rtl/bfer_if.sv
hw/rtl/bfer_ctrl.sv
hw/rtl/bfer_datapath.sv
hw/rtl/backlight_fade_easing_ramp_core.sv
tb/tb_backlight_fade_easing_ramp_core.sv
